// ----- hw/rtl/scu_pkg.sv -----
package scu_pkg;

  // datapath word width, shared by the beat types
  localparam int WORD_BITS = 32;

  typedef enum logic [2:0] {
    CMD_ADD  = 3'd0,
    CMD_SUB  = 3'd1,
    CMD_MUL  = 3'd2,
    CMD_DIV  = 3'd3,
    CMD_FACT = 3'd4,
    CMD_POW  = 3'd5,
    CMD_PASS = 3'd6,
    CMD_PAS2 = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_DIV0 = 2'd1,
    ST_OVF = 2'd2,
    ST_RSV = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIN,
    S_MUL,
    S_DIV,
    S_FACT,
    S_POW,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [2:0]           command;
    logic [WORD_BITS-1:0] operand_a;
    logic [WORD_BITS-1:0] operand_b;
  } in_beat_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] result;
    logic [1:0]           status;
  } out_beat_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture operands, set up the operation
    logic step;     // one iteration of the active loop
    logic finish;   // latch final result (add, sub, pass, div0)
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic loop_done;
  } sts_t;

endpackage

// ----- hw/rtl/scalar_calculator_unit.sv -----
// operations: add, sub, pass latch in S_FIN; mul in S_MUL; div one quotient bit a
//   cycle over WORD_BITS + FRAC_BITS dividend bits, via finish on a zero divisor;
//   factorial and power one multiply per cycle up to the loop count (early exit)
// throughput: one item at a time; busy is high in every state past idle, through the
//   result strobe, and the next beat can be taken in the cycle after it
// reset: rst_ni asynchronous, active low, controller to idle; no result stall
module scalar_calculator_unit
  import scu_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  in_beat_t  in_i,
  output logic      done_o,
  output out_beat_t out_o
);

  ctl_t   ctl;
  sts_t   sts;
  state_e state;
  in_beat_t in_q;
  logic   b_zero;

  // hold the input beat for the whole operation
  always_ff @(posedge clk_i) begin
    if (start && !busy) in_q <= in_i;
  end

  assign b_zero = (in_q.operand_b == '0);

  scu_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .cmd_i    (cmd_e'(in_i.command)),
    .b_zero_i (b_zero),
    .sts_i    (sts),
    .ctl_o    (ctl),
    .state_o  (state),
    .busy_o   (busy),
    .done_o   (done_o)
  );

  scu_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (ctl.load ? in_i : in_q),
    .state_i (state),
    .ctl_i   (ctl),
    .sts_o   (sts),
    .out_o   (out_o)
  );

endmodule

// ----- hw/rtl/scu_datapath.sv -----
module scu_datapath
  import scu_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_beat_t  in_i,
  input  state_e    state_i,
  input  ctl_t      ctl_i,
  output sts_t      sts_o,
  output out_beat_t out_o
);

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int PW = 2 * W;
  localparam int DW = W + F;        // dividend width
  localparam int CW = $clog2(DW + 1);
  localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
  localparam bit ONE_OVF = (F >= W - 1);
  localparam logic [W-1:0] ONE = ONE_OVF ? WMAX : W'(64'd1 << F);

  logic [W-1:0]  a_q, b_q, acc_q, p1_q;
  logic [W-1:0]  res_q;
  logic [1:0]    st_q;
  logic [W-1:0]  cnt_q;   // loop count
  logic [W-1:0]  k_q;     // iteration index
  logic          done_q;
  // divider
  logic [DW-1:0] num_q;
  logic [W-1:0]  rem_q;
  logic [DW-1:0] quo_q;
  logic [CW-1:0] dcnt_q;
  logic          dneg_q;

  // magnitude multiplier for mul and power
  logic [W-1:0]  ma, mb, mag_a, mag_b;
  logic          mneg;
  logic [PW-1:0] prod;
  logic [PW-1:0] shq;
  logic          rem_nz;
  logic [PW:0]   qmag;
  logic          mul_neg;
  logic [W-1:0]  mul_res;
  logic          mul_ovf;

  function automatic logic [W-1:0] absw(input logic [W-1:0] v);
    return v[W-1] ? (~v + W'(1)) : v;
  endfunction

  // saturate magnitude with sign
  function automatic logic [W:0] sat(input logic [PW:0] m, input logic neg);
    logic [PW:0] lim;
    lim = neg ? (PW+1)'(WMIN) : (PW+1)'(WMAX);
    if (m > lim) return {1'b1, neg ? WMIN : WMAX};
    return {1'b0, neg ? (~m[W-1:0] + W'(1)) : m[W-1:0]};
  endfunction

  always_comb begin
    ma = acc_q;
    mb = a_q;
    if (state_i == S_MUL) begin
      ma = a_q;
      mb = b_q;
    end
    mag_a = absw(ma);
    mag_b = absw(mb);
    mneg  = ma[W-1] ^ mb[W-1];
    prod  = PW'(mag_a) * PW'(mag_b);
    shq   = prod >> F;
    rem_nz = (F > 0) ? |(prod & ~(PW'(-1) << F)) : 1'b0;
    qmag  = {1'b0, shq} + (PW+1)'(mneg && rem_nz);
    mul_neg = mneg && (qmag != '0);
    {mul_ovf, mul_res} = sat(qmag, mul_neg);
  end

  // factorial step: acc * k (integer), overflow against WMAX
  logic [PW-1:0] fprod;
  assign fprod = PW'(acc_q) * PW'(k_q);

  logic [W:0] rem_sh;
  logic [W:0] rem_sub;
  assign rem_sh  = {rem_q, num_q[DW-1]};
  assign rem_sub = rem_sh - {1'b0, b_q};

  logic [W:0] add_s, sub_s;
  assign add_s = {a_q[W-1], a_q} + {b_q[W-1], b_q};
  assign sub_s = {a_q[W-1], a_q} - {b_q[W-1], b_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      st_q   <= ST_OK;
      res_q  <= '0;
    end else if (ctl_i.load) begin
      a_q    <= in_i.operand_a[W-1:0];
      b_q    <= (cmd_e'(in_i.command) == CMD_DIV) ? absw(in_i.operand_b[W-1:0])
                                                  : in_i.operand_b[W-1:0];
      acc_q  <= ONE;
      p1_q   <= ONE;
      st_q   <= ONE_OVF ? ST_OVF : ST_OK;
      k_q    <= W'(1);
      cnt_q  <= (cmd_e'(in_i.command) == CMD_FACT)
              ? (in_i.operand_a[W-1] ? '0 : W'(in_i.operand_a[W-1:0] >> F))
              : (in_i.operand_b[W-1] ? '0 : W'(in_i.operand_b[W-1:0] >> F));
      num_q  <= DW'(absw(in_i.operand_a[W-1:0])) << F;
      rem_q  <= '0;
      quo_q  <= '0;
      dcnt_q <= CW'(DW);
      dneg_q <= in_i.operand_a[W-1] ^ in_i.operand_b[W-1];
      done_q <= 1'b0;
    end else if (ctl_i.finish) begin
      unique case (cmd_e'(in_i.command))
        CMD_ADD: begin
          res_q <= (add_s[W] != add_s[W-1]) ? (add_s[W] ? WMIN : WMAX) : add_s[W-1:0];
          st_q  <= (add_s[W] != add_s[W-1]) ? ST_OVF : ST_OK;
        end
        CMD_SUB: begin
          res_q <= (sub_s[W] != sub_s[W-1]) ? (sub_s[W] ? WMIN : WMAX) : sub_s[W-1:0];
          st_q  <= (sub_s[W] != sub_s[W-1]) ? ST_OVF : ST_OK;
        end
        CMD_DIV: begin
          res_q <= '0;
          st_q  <= ST_DIV0;
        end
        default: begin
          res_q <= a_q;
          st_q  <= ST_OK;
        end
      endcase
    end else if (ctl_i.step) begin
      unique case (state_i)
        S_MUL: begin
          res_q <= mul_res;
          st_q  <= mul_ovf ? ST_OVF : ST_OK;
          done_q <= 1'b1;
        end
        S_DIV: begin
          if (!rem_sub[W]) begin
            rem_q <= rem_sub[W-1:0];
            quo_q <= {quo_q[DW-2:0], 1'b1};
          end else begin
            rem_q <= rem_sh[W-1:0];
            quo_q <= {quo_q[DW-2:0], 1'b0};
          end
          num_q  <= num_q << 1;
          dcnt_q <= dcnt_q - CW'(1);
          if (dcnt_q == CW'(1)) done_q <= 1'b1;
        end
        S_FACT: begin
          if (k_q > cnt_q) begin
            res_q <= acc_q; done_q <= 1'b1;
          end else if (fprod > PW'(WMAX)) begin
            res_q <= WMAX; st_q <= ST_OVF; done_q <= 1'b1;
          end else begin
            acc_q <= fprod[W-1:0];
            k_q   <= k_q + W'(1);
          end
        end
        S_POW: begin
          if (k_q > cnt_q) begin
            res_q <= acc_q; done_q <= 1'b1;
          end else if (mul_ovf) begin
            res_q <= mul_res; st_q <= ST_OVF; done_q <= 1'b1;
          end else if (mul_res == acc_q) begin
            res_q <= mul_res; done_q <= 1'b1;
          end else if (k_q >= W'(2) && mul_res == p1_q) begin
            // oscillation between two values: pick by parity of remaining steps
            res_q <= ((cnt_q - k_q) & W'(1)) != '0 ? acc_q : mul_res;
            done_q <= 1'b1;
          end else begin
            p1_q  <= acc_q;
            acc_q <= mul_res;
            k_q   <= k_q + W'(1);
          end
        end
        default: done_q <= 1'b1;
      endcase
    end
  end

  // divider result, formed combinationally from the finished quotient
  logic [PW:0] dmag;
  logic        dres_neg;
  logic [W:0]  dsat;
  assign dmag     = (PW+1)'(quo_q);
  assign dres_neg = dneg_q && (quo_q != '0);
  assign dsat     = sat(dmag, dres_neg);

  assign sts_o.loop_done = done_q;

  always_comb begin
    out_o.result = res_q;
    out_o.status = st_q;
    if (state_i == S_DONE && cmd_e'(in_i.command) == CMD_DIV && b_q != '0) begin
      out_o.result = dsat[W-1:0];
      out_o.status = dsat[W] ? ST_OVF : ST_OK;
    end
  end

endmodule

// ----- hw/rtl/scu_ctrl.sv -----
module scu_ctrl
  import scu_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start_i,
  input  cmd_e   cmd_i,
  input  logic   b_zero_i,
  input  sts_t   sts_i,
  output ctl_t   ctl_o,
  output state_e state_o,
  output logic   busy_o,
  output logic   done_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    done_o  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          ctl_o.load = 1'b1;
          unique case (cmd_i)
            CMD_MUL:  state_d = S_MUL;
            CMD_DIV:  state_d = S_DIV;
            CMD_FACT: state_d = S_FACT;
            CMD_POW:  state_d = S_POW;
            default:  state_d = S_FIN;
          endcase
        end
      end
      S_FIN: begin
        ctl_o.finish = 1'b1;
        state_d = S_DONE;
      end
      S_MUL, S_FACT, S_POW: begin
        if (sts_i.loop_done) state_d = S_DONE;
        else ctl_o.step = 1'b1;
      end
      S_DIV: begin
        if (b_zero_i) begin
          ctl_o.finish = 1'b1;
          state_d = S_DONE;
        end else if (sts_i.loop_done) begin
          state_d = S_DONE;
        end else begin
          ctl_o.step = 1'b1;
        end
      end
      S_DONE: begin
        done_o  = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign state_o = state_q;
  assign busy_o  = (state_q != S_IDLE);

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (state_q == S_IDLE)) else $error("done not followed by idle");
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.load |-> (state_q == S_IDLE)) else $error("load while busy");
  a_no_step_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !ctl_o.step) else $error("step while idle");

endmodule
